// ===== sv/assert_macros.svh =====
// Assertion macros used by the table core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion on clk_i, disabled while reset is asserted.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never hold at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`endif

// ===== sv/prt_pkg.sv =====
// Types and constants for the pairing rendezvous table.
package prt_pkg;
  localparam int unsigned TableEntries = 16;
  localparam int unsigned SlotW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned CntW = $clog2(TableEntries + 1);

  localparam logic [2:0] OpBegin   = 3'd0;
  localparam logic [2:0] OpCancel  = 3'd1;
  localparam logic [2:0] OpHeard   = 3'd2;
  localparam logic [2:0] OpSend    = 3'd3;
  localparam logic [2:0] OpOutcome = 3'd4;

  localparam logic [1:0] KindAnnounce = 2'd0;
  localparam logic [1:0] KindPaired   = 2'd1;
  localparam logic [1:0] KindTimeout  = 2'd2;
  localparam logic [1:0] KindDone     = 2'd3;

  localparam logic RegTimeout = 1'b0;
  localparam logic RegResend  = 1'b1;

  localparam logic [31:0] TimeoutReset = 32'd1000;
  localparam logic [31:0] ResendReset  = 32'd100;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] cookie;
    logic [7:0]  side_index;
    logic [31:0] address;
    logic [15:0] port;
    logic        partner_heard_flag;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_cookie;
    logic [7:0]  out_index;
    logic [31:0] out_address;
    logic [15:0] out_port;
    logic        knows_partner;
    logic        status;
    logic        last;
  } res_t;

  // Saturating 32-bit add for deadlines.
  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

// ===== sv/pairing_rendezvous_table_core.sv =====
// Pairing rendezvous table: keyed slot table with sequential scans.
//
// Usage: drive req_i and raise start while busy is low; the request is
// taken at that edge and busy rises. The block walks the slots one per
// cycle: a search pass for begin, cancel and heard, then for begin an
// optional free-slot pass, or a single scan pass for send and outcome; an
// unused opcode goes straight to the done step. Each result appears on
// res_o for exactly one cycle with res_valid_o high; at most one per slot,
// then a done result with last set, shown in the cycle where busy falls.
// The receiver cannot stall, so the block never waits on the output. The
// walk through the slot memory, with compare and saturating-add logic shared
// by all slots, sets the rate. Configuration writes (cfg_valid_i/cfg_ready_o
// with cfg_index_i and cfg_data_i) take effect at once and are meant for idle
// time. Reset clears all valid bits and restores register defaults; no
// clearing pass is needed.
module pairing_rendezvous_table_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  prt_pkg::req_t  req_i,
  output logic           res_valid_o,
  output prt_pkg::res_t  res_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [31:0]    cfg_data_i
);
  import prt_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {StIdle, StSearch, StFree, StScan, StDone} state_e;

  typedef struct packed {
    logic [31:0] cookie;
    logic [7:0]  side;
    logic [31:0] own_addr;
    logic [15:0] own_port;
    logic [31:0] expiry;
    logic [31:0] send;
    logic        pknown;
    logic [31:0] paddr;
    logic [15:0] pport;
    logic        heard;
    logic        told;
    logic        rep;
  } entry_t;

  entry_t                  mem_q [TableEntries];
  logic [TableEntries-1:0] valid_q;
  logic [31:0] timeout_q, resend_q;
  state_e      state_q;
  req_t        req_q;
  logic [CntW-1:0] idx_q;
  logic        found_q;
  logic [SlotW-1:0] hit_q;
  logic        status_q;
  logic        res_valid_q;
  res_t        res_q;

  logic [SlotW-1:0] slot;
  entry_t cur, nxt;
  logic   cur_v, wr_en, clr_v, set_v;
  logic   out_en;
  res_t   out_d;
  logic   expired;

  // End of search parks on the hit slot
  assign slot = (state_q == StSearch && idx_q == CntW'(TableEntries)) ? hit_q
                                                                      : idx_q[SlotW-1:0];
  assign cur = mem_q[slot];
  assign cur_v = valid_q[slot];
  assign expired = req_q.now >= cur.expiry;
  assign busy = (state_q != StIdle);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;

  // Per-slot action, one slot per cycle: scans, search end, free pass, done
  always_comb begin
    nxt = cur;
    wr_en = 1'b0;
    clr_v = 1'b0;
    set_v = 1'b0;
    out_en = 1'b0;
    out_d = '0;
    if (state_q == StScan && cur_v) begin
      if (req_q.opcode == OpSend) begin
        if (!((cur.heard && cur.told) || req_q.now < cur.send)) begin
          wr_en = 1'b1;
          nxt.send = sat_add(req_q.now, resend_q);
          if (cur.pknown) nxt.told = 1'b1;
          out_en = 1'b1;
          out_d.kind = KindAnnounce;
          out_d.out_cookie = cur.cookie;
          out_d.out_index = cur.side;
          out_d.out_address = cur.own_addr;
          out_d.out_port = cur.own_port;
          out_d.knows_partner = cur.pknown;
        end
      end else begin
        // Paired and timeout are exclusive, so one result per slot
        if (cur.pknown && !cur.rep) begin
          wr_en = 1'b1;
          nxt.rep = 1'b1;
          out_en = 1'b1;
          out_d.kind = KindPaired;
          out_d.out_cookie = cur.cookie;
          out_d.out_address = cur.paddr;
          out_d.out_port = cur.pport;
        end else if (!cur.pknown && expired) begin
          out_en = 1'b1;
          out_d.kind = KindTimeout;
          out_d.out_cookie = cur.cookie;
        end
        if (expired || (nxt.rep && cur.heard && cur.told)) clr_v = 1'b1;
      end
    end else if (state_q == StSearch && idx_q == CntW'(TableEntries)) begin
      // End of search: apply single-slot operations
      if (req_q.opcode == OpCancel && found_q) begin
        clr_v = 1'b1;
      end else if (req_q.opcode == OpHeard && found_q && cur.side != req_q.side_index) begin
        wr_en = 1'b1;
        if (!cur.pknown) begin
          nxt.pknown = 1'b1;
          nxt.paddr = req_q.address;
          nxt.pport = req_q.port;
          nxt.send = '0;
        end
        if (req_q.partner_heard_flag) nxt.heard = 1'b1;
      end else if (req_q.opcode == OpBegin && found_q) begin
        wr_en = 1'b1;
        set_v = 1'b1;
      end
    end else if (state_q == StFree && !cur_v) begin
      wr_en = 1'b1;
      set_v = 1'b1;
    end else if (state_q == StDone) begin
      // Closing result of the run
      out_en = 1'b1;
      out_d.kind = KindDone;
      out_d.status = status_q;
      out_d.last = 1'b1;
    end
    if (set_v) begin
      nxt.cookie = req_q.cookie;
      nxt.side = req_q.side_index;
      nxt.own_addr = req_q.address;
      nxt.own_port = req_q.port;
      nxt.expiry = sat_add(req_q.now, timeout_q);
      nxt.send = req_q.now;
      nxt.pknown = 1'b0;
      nxt.paddr = '0;
      nxt.pport = '0;
      nxt.heard = 1'b0;
      nxt.told = 1'b0;
      nxt.rep = 1'b0;
    end
  end

  // Slot memory write; the slot read above uses hit_q at end of search
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[slot] <= nxt;
  end

  // Sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      valid_q <= '0;
      timeout_q <= TimeoutReset;
      resend_q <= ResendReset;
      idx_q <= '0;
      found_q <= 1'b0;
      hit_q <= '0;
      status_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_q <= '0;
      req_q <= '0;
    end else begin
      res_valid_q <= out_en;
      if (out_en) res_q <= out_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == RegTimeout) timeout_q <= cfg_data_i;
        else resend_q <= cfg_data_i;
      end
      if (clr_v) valid_q[slot] <= 1'b0;
      if (set_v) valid_q[slot] <= 1'b1;
      case (state_q)
        StIdle: begin
          if (start) begin
            req_q <= req_i;
            idx_q <= '0;
            found_q <= 1'b0;
            status_q <= 1'b0;
            if (req_i.opcode inside {OpSend, OpOutcome}) state_q <= StScan;
            else if (req_i.opcode inside {OpBegin, OpCancel, OpHeard}) state_q <= StSearch;
            else state_q <= StDone;
          end
        end
        StSearch: begin
          if (idx_q == CntW'(TableEntries)) begin
            if (req_q.opcode == OpBegin && !found_q) begin
              state_q <= StFree;
              idx_q <= '0;
            end else begin
              state_q <= StDone;
            end
          end else begin
            if (!found_q && cur_v && cur.cookie == req_q.cookie) begin
              found_q <= 1'b1;
              hit_q <= slot;
            end
            // Park on the hit slot for the final step
            if (idx_q == CntW'(TableEntries - 1)) begin
              idx_q <= CntW'(TableEntries);
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        StFree: begin
          if (!cur_v) begin
            state_q <= StDone;
          end else if (idx_q == CntW'(TableEntries - 1)) begin
            status_q <= 1'b1;
            state_q <= StDone;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StScan: begin
          if (idx_q == CntW'(TableEntries - 1)) state_q <= StDone;
          else idx_q <= idx_q + 1'b1;
        end
        StDone: begin
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `ASSERT_PROP(a_done_ends, (state_q == StDone) |=> (res_valid_o && res_o.last), "done missing")
  `ASSERT_PROP(a_last_done, (res_valid_o && res_o.last) |-> (res_o.kind == KindDone), "bad last")
  `ASSERT_PROP(a_busy_after_start, (start && !busy) |=> busy, "not busy after start")
  `ASSERT_PROP(a_status_begin, (res_valid_o && res_o.status) |-> (req_q.opcode == OpBegin), "status")
  `ASSERT_NEVER(a_done_busy, res_valid_o && res_o.last && busy, "done while busy")
endmodule

// ===== sim/pairing_rendezvous_table_checker.sv =====
// Checker for the pairing rendezvous table: predicts results and compares them.
`timescale 1ns / 100ps

module pairing_rendezvous_table_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  prt_pkg::req_t req_i,
  input  logic          res_valid_o,
  input  prt_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  input  logic          cfg_ready_o,
  input  logic          cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            result_count_o
);
  import prt_pkg::*;

  localparam int Slots = TableEntries;

  // shadow of the table and registers
  logic [31:0] timeout_ticks, resend_ticks;
  logic        slot_used   [Slots];
  logic [31:0] slot_cookie [Slots];
  logic [7:0]  slot_side   [Slots];
  logic [31:0] slot_addr   [Slots];
  logic [15:0] slot_port   [Slots];
  logic [31:0] slot_expiry [Slots];
  logic [31:0] slot_send   [Slots];
  logic        peer_known  [Slots];
  logic [31:0] peer_addr   [Slots];
  logic [15:0] peer_port   [Slots];
  logic        peer_heard  [Slots];
  logic        peer_told   [Slots];
  logic        slot_reported [Slots];

  res_t expected_q[$];
  int   fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic [31:0] clamp_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int lookup_slot(logic [31:0] key);
    for (int i = 0; i < Slots; i++)
      if (slot_used[i] && slot_cookie[i] == key) return i;
    return -1;
  endfunction

  function automatic void queue_result(logic [1:0] kind, logic [31:0] ck, logic [7:0] idx,
                                       logic [31:0] addr, logic [15:0] prt, logic knows,
                                       logic st, logic lst);
    res_t r;
    r.kind = kind; r.out_cookie = ck; r.out_index = idx; r.out_address = addr;
    r.out_port = prt; r.knows_partner = knows; r.status = st; r.last = lst;
    expected_q = {expected_q, r};
  endfunction

  // apply one request to the shadow table and queue what it should emit
  function automatic void run_request(req_t r);
    int  s;
    logic full_flag;
    logic gone;
    full_flag = 1'b0;
    case (r.opcode)
      OpBegin: begin
        s = lookup_slot(r.cookie);
        if (s < 0)
          for (int i = Slots - 1; i >= 0; i--) if (!slot_used[i]) s = i;
        if (s < 0) begin
          full_flag = 1'b1;
        end else begin
          slot_used[s] = 1'b1; slot_cookie[s] = r.cookie; slot_side[s] = r.side_index;
          slot_addr[s] = r.address; slot_port[s] = r.port;
          slot_expiry[s] = clamp_sum(r.now, timeout_ticks);
          slot_send[s] = r.now;
          peer_known[s] = 1'b0; peer_addr[s] = '0; peer_port[s] = '0;
          peer_heard[s] = 1'b0; peer_told[s] = 1'b0; slot_reported[s] = 1'b0;
        end
      end
      OpCancel: begin
        s = lookup_slot(r.cookie);
        if (s >= 0) slot_used[s] = 1'b0;
      end
      OpHeard: begin
        s = lookup_slot(r.cookie);
        if (s >= 0 && slot_side[s] != r.side_index) begin
          if (!peer_known[s]) begin
            peer_known[s] = 1'b1; peer_addr[s] = r.address; peer_port[s] = r.port;
            slot_send[s] = '0;
          end
          if (r.partner_heard_flag) peer_heard[s] = 1'b1;
        end
      end
      OpSend: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i] && !(peer_heard[i] && peer_told[i]) && r.now >= slot_send[i]) begin
            slot_send[i] = clamp_sum(r.now, resend_ticks);
            if (peer_known[i]) peer_told[i] = 1'b1;
            queue_result(KindAnnounce, slot_cookie[i], slot_side[i], slot_addr[i],
                         slot_port[i], peer_known[i], 1'b0, 1'b0);
          end
        end
      end
      OpOutcome: begin
        for (int i = 0; i < Slots; i++) begin
          if (slot_used[i]) begin
            if (peer_known[i] && !slot_reported[i]) begin
              slot_reported[i] = 1'b1;
              queue_result(KindPaired, slot_cookie[i], '0, peer_addr[i], peer_port[i],
                           1'b0, 1'b0, 1'b0);
            end
            gone = r.now >= slot_expiry[i];
            if (!peer_known[i] && gone)
              queue_result(KindTimeout, slot_cookie[i], '0, '0, '0, 1'b0, 1'b0, 1'b0);
            if (gone || (slot_reported[i] && peer_heard[i] && peer_told[i]))
              slot_used[i] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    queue_result(KindDone, '0, '0, '0, '0, 1'b0, full_flag, 1'b1);
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    fails++;
  endtask

  // watch the channels
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      timeout_ticks  = TimeoutReset;
      resend_ticks   = ResendReset;
      fails          = 0;
      result_count_o = 0;
      expected_q.delete();
      for (int i = 0; i < Slots; i++) begin
        slot_used[i] = 1'b0; slot_cookie[i] = '0; slot_side[i] = '0; slot_addr[i] = '0;
        slot_port[i] = '0; slot_expiry[i] = '0; slot_send[i] = '0; peer_known[i] = 1'b0;
        peer_addr[i] = '0; peer_port[i] = '0; peer_heard[i] = 1'b0; peer_told[i] = 1'b0;
        slot_reported[i] = 1'b0;
      end
    end else begin
      if (res_valid_o) begin
        result_count_o++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result kind", 32'(res_o.kind), 32'h0);
        end else begin
          want = expected_q.pop_front();
          if (res_o.kind !== want.kind)
            report_mismatch("kind", 32'(res_o.kind), 32'(want.kind));
          if (res_o.out_cookie !== want.out_cookie)
            report_mismatch("cookie", res_o.out_cookie, want.out_cookie);
          if (res_o.out_index !== want.out_index)
            report_mismatch("index", 32'(res_o.out_index), 32'(want.out_index));
          if (res_o.out_address !== want.out_address)
            report_mismatch("address", res_o.out_address, want.out_address);
          if (res_o.out_port !== want.out_port)
            report_mismatch("port", 32'(res_o.out_port), 32'(want.out_port));
          if (res_o.knows_partner !== want.knows_partner)
            report_mismatch("knows_partner", 32'(res_o.knows_partner),
                            32'(want.knows_partner));
          if (res_o.status !== want.status)
            report_mismatch("status", 32'(res_o.status), 32'(want.status));
          if (res_o.last !== want.last)
            report_mismatch("last", 32'(res_o.last), 32'(want.last));
        end
      end
      if (start && !busy) run_request(req_i);
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == RegTimeout) timeout_ticks = cfg_data_i;
        else resend_ticks = cfg_data_i;
      end
    end
  end
endmodule

// ===== sim/tb_pairing_rendezvous_table_core.sv =====
// Testbench top for the pairing rendezvous table: stimulus and verdict.
`timescale 1ns / 100ps

module tb_pairing_rendezvous_table_core;
  import prt_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int PoolSize = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start;
  logic        busy;
  req_t        req_i;
  logic        res_valid_o;
  res_t        res_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;
  int          fail_count, pending, result_count;
  int          quiet_cycles;
  int          op_count[8];
  int          sender_idle_pct;

  logic [31:0] cookie_pool[PoolSize];
  logic [7:0]  side_of[PoolSize];
  logic [31:0] tick;

  always #4 clk_i = ~clk_i;

  pairing_rendezvous_table_core dut (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  pairing_rendezvous_table_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .req_i, .res_valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  // watchdog: cycles with no handshake of any kind
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o || (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("timeout: no activity for %0d cycles", WatchdogLimit);
      $display("== FAIL ==");
      $finish;
    end
  end

  // present one request and hold it until taken
  task automatic issue(req_t r);
    req_i <= r;
    start <= 1'b1;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    op_count[r.opcode]++;
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // wait until the table is quiet and every result is in
  task automatic drain();
    @(posedge clk_i);
    start <= 1'b0;
    @(negedge clk_i);
    while (busy || pending != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic req_t make_req(logic [2:0] op, int k, logic [31:0] now);
    req_t r;
    r.opcode = op;
    r.cookie = cookie_pool[k];
    r.side_index = 8'($urandom_range(255));
    r.address = $urandom;
    r.port = 16'($urandom_range(65535));
    r.partner_heard_flag = 1'($urandom_range(1));
    r.now = now;
    return r;
  endfunction

  // one random request, mostly well-formed pairing traffic
  task automatic random_request();
    req_t r;
    int   k, pick;
    k = $urandom_range(PoolSize - 1);
    pick = $urandom_range(99);
    tick = tick + $urandom_range(0, 250);
    if (pick < 30) begin
      r = make_req(OpBegin, k, tick);
      side_of[k] = r.side_index;
    end else if (pick < 55) begin
      r = make_req(OpHeard, k, tick);
      if ($urandom_range(4) == 0) r.side_index = side_of[k];
      else r.side_index = side_of[k] ^ (8'd1 << $urandom_range(7));
    end else if (pick < 70) r = make_req(OpSend, k, tick);
    else if (pick < 85) r = make_req(OpOutcome, k, tick);
    else if (pick < 95) r = make_req(OpCancel, k, tick);
    else r = make_req(3'($urandom_range(5, 7)), k, tick);
    if ($urandom_range(19) == 0) r.now = $urandom;
    issue(r);
  endtask

  initial begin
    req_t r;
    start       <= 1'b0;
    req_i       <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= 1'b0;
    cfg_data_i  <= '0;
    sender_idle_pct = 0;
    tick = 0;
    cookie_pool[0] = 32'h0;
    cookie_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < PoolSize; i++) cookie_pool[i] = $urandom;
    for (int i = 0; i < PoolSize; i++) side_of[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: pairing on the extreme cookies, ignored and repeated heard
    r = make_req(OpBegin, 0, 32'h0);
    r.side_index = 8'h00; r.address = 32'h0; r.port = 16'h0; side_of[0] = 8'h00;
    issue(r);
    r = make_req(OpBegin, 1, 32'hFFFF_FF00);
    r.side_index = 8'hFF; r.address = 32'hFFFF_FFFF; r.port = 16'hFFFF; side_of[1] = 8'hFF;
    issue(r);
    r = make_req(OpSend, 0, 32'h0); issue(r);
    r = make_req(OpHeard, 0, 32'h0); r.side_index = 8'h00; issue(r);
    r = make_req(OpHeard, 0, 32'h0); r.side_index = 8'h01; r.partner_heard_flag = 1'b0;
    issue(r);
    r = make_req(OpHeard, 0, 32'h0); r.side_index = 8'h02; r.partner_heard_flag = 1'b1;
    issue(r);
    r = make_req(OpSend, 0, 32'h5); issue(r);
    r = make_req(OpOutcome, 0, 32'h5); issue(r);
    r = make_req(OpBegin, 1, 32'h10); r.side_index = 8'h7F; side_of[1] = 8'h7F; issue(r);
    r = make_req(OpCancel, 2, 32'h0); issue(r);
    r = make_req(OpHeard, 3, 32'h0); issue(r);
    r = make_req(3'd5, 0, 32'h0); issue(r);
    r = make_req(3'd7, 0, 32'hFFFF_FFFF); issue(r);
    r = make_req(OpCancel, 1, 32'h0); issue(r);
    // fill the table, then one more begin is refused
    for (int i = 2; i < 19; i++) begin
      r = make_req(OpBegin, i, 32'h20); side_of[i] = r.side_index; issue(r);
    end
    r = make_req(OpSend, 0, 32'hFFFF_FFFF); issue(r);
    r = make_req(OpOutcome, 0, 32'hFFFF_FFFF); issue(r);
    drain();

    // random phases under different register settings and idling
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin write_reg(RegTimeout, 32'h0); write_reg(RegResend, 32'hFFFF_FFFF); end
        1: begin write_reg(RegTimeout, 32'hFFFF_FFFF); write_reg(RegResend, 32'h0); end
        2: begin write_reg(RegTimeout, $urandom_range(200, 2000));
                 write_reg(RegResend, $urandom_range(20, 300)); end
        default: begin write_reg(RegTimeout, TimeoutReset); write_reg(RegResend, ResendReset); end
      endcase
      sender_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 50 : 0;
      tick = (phase == 1) ? 32'hFFFF_F000 : 32'h0;
      for (int n = 0; n < 32; n++) random_request();
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("covered %0d begin, %0d cancel, %0d heard, %0d send, %0d outcome requests",
             op_count[0], op_count[1], op_count[2], op_count[3], op_count[4]);
    $display("%0d unused-opcode requests, %0d results checked",
             op_count[5] + op_count[6] + op_count[7], result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/prt_pkg.sv
sv/pairing_rendezvous_table_core.sv
sim/pairing_rendezvous_table_checker.sv
sim/tb_pairing_rendezvous_table_core.sv
